[hw/rtl/nrt_pkg.sv]
// ----------------------------------------------------------------------------
// nrt_pkg
// Shared constants, types and codes for the node roster table.
// ----------------------------------------------------------------------------
`default_nettype none

package nrt_pkg;

  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 64;
  localparam int LOC_BITS = 64;

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int FUNC_W  = 2;
  localparam int KEYF_W  = 64;
  localparam int LOCF_W  = 64;
  localparam int TIME_W  = 32;
  localparam int IDXF_W  = 4;
  localparam int OCCF_W  = 5;

  localparam logic [TIME_W-1:0] STALE_LIMIT_RST = 32'd60000;

  localparam logic [FUNC_W-1:0] FN_TOUCH = 2'd0;
  localparam logic [FUNC_W-1:0] FN_QUERY = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [LOC_BITS-1:0] loc;
    logic [TIME_W-1:0]   epoch;
    logic [TIME_W-1:0]   last_seen;
  } nrt_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic             load;
    logic             scan_clr;
    logic             rd_en;
    logic             rd_use_idx;
    logic [IDX_W-1:0] rd_addr;
    logic             finish;
  } nrt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              key_zero;
    logic [CNT_W-1:0]  occupied;
    logic              out_hold;
  } nrt_sts_t;

endpackage

`default_nettype wire

[hw/rtl/nrt_in_if.sv]
// ----------------------------------------------------------------------------
// nrt_in_if
// Request channel: valid/ready handshake with the operation fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface nrt_in_if import nrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEYF_W-1:0] node_key;
  logic [LOCF_W-1:0] location_data;
  logic              location_present;
  logic [TIME_W-1:0] wall_secs;
  logic [TIME_W-1:0] now_ms;
  logic [IDXF_W-1:0] entry_index;

  modport source (output valid, func, node_key, location_data, location_present,
                  wall_secs, now_ms, entry_index, input ready);
  modport sink (input valid, func, node_key, location_data, location_present,
                wall_secs, now_ms, entry_index, output ready);
endinterface

`default_nettype wire

[hw/rtl/nrt_out_if.sv]
// ----------------------------------------------------------------------------
// nrt_out_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface nrt_out_if import nrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              stale;
  logic              entry_valid;
  logic [KEYF_W-1:0] entry_key;
  logic [LOCF_W-1:0] entry_location;
  logic [TIME_W-1:0] entry_epoch;
  logic [TIME_W-1:0] entry_last_seen;
  logic              entry_online;
  logic [OCCF_W-1:0] occupied_count;
  logic [IDXF_W-1:0] touched_slot;

  modport source (output valid, stale, entry_valid, entry_key, entry_location,
                  entry_epoch, entry_last_seen, entry_online, occupied_count,
                  touched_slot, input ready);
  modport sink (input valid, stale, entry_valid, entry_key, entry_location,
                entry_epoch, entry_last_seen, entry_online, occupied_count,
                touched_slot, output ready);
endinterface

`default_nettype wire

[hw/rtl/nrt_ctrl.sv]
// ----------------------------------------------------------------------------
// nrt_ctrl
// Sequencer: decodes the latched item, walks the occupied slots, finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module nrt_ctrl import nrt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire nrt_sts_t sts,
  output nrt_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cmd            = '0;
    cmd.rd_addr    = cnt_r[IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DEC;
        end
      end
      S_DEC: begin
        if ((sts.func == FN_TOUCH || sts.func == FN_QUERY) && !sts.key_zero) begin
          state_nxt = S_SCAN;
        end else if (sts.func == FN_READ) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        // last compare happens in the cycle after the last read issue
        if (cnt_r < sts.occupied) begin
          cmd.rd_en = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RD: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_use_idx = 1'b1;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_hold) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/nrt_dp.sv]
// ----------------------------------------------------------------------------
// nrt_dp
// Datapath: item latch, slot memory, scan compare, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nrt_dp import nrt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire nrt_cmd_t          cmd,
  output nrt_sts_t               sts,
  input  wire logic              cfg_we,
  input  wire logic [TIME_W-1:0] cfg_wdata,
  nrt_in_if.sink                 in_ch,
  nrt_out_if.source              out_ch
);

  // latched item
  logic [FUNC_W-1:0]   func_r;
  logic [KEY_BITS-1:0] key_r;
  logic [LOC_BITS-1:0] loc_r;
  logic [TIME_W-1:0]   epoch_r;
  logic [TIME_W-1:0]   now_r;
  logic [IDXF_W-1:0]   idx_r;

  logic [TIME_W-1:0]   limit_r;
  logic [CNT_W-1:0]    occ_r;

  nrt_entry_t          mem [ENTRIES];
  nrt_entry_t          rd_q_r;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    rd_idx_r;
  logic                rd_vld_r;

  logic                found_r;
  logic [IDX_W-1:0]    found_slot_r;
  logic [TIME_W-1:0]   found_age_r;
  logic                best_vld_r;
  logic [IDX_W-1:0]    best_slot_r;
  logic [TIME_W-1:0]   best_age_r;

  logic [TIME_W-1:0]   rd_age;
  logic                full;
  logic                do_write;
  logic [IDX_W-1:0]    wr_slot;
  logic [CNT_W-1:0]    occ_nxt;
  logic                rd_in_range;

  logic                out_valid_r;
  logic                stale_r;
  logic                ev_r;
  logic [KEYF_W-1:0]   ekey_r;
  logic [LOCF_W-1:0]   eloc_r;
  logic [TIME_W-1:0]   eepoch_r;
  logic [TIME_W-1:0]   elast_r;
  logic                eonline_r;
  logic [OCCF_W-1:0]   occ_out_r;
  logic [IDXF_W-1:0]   tslot_r;

  assign sts.func     = func_r;
  assign sts.key_zero = (key_r == '0);
  assign sts.occupied = occ_r;
  assign sts.out_hold = out_valid_r && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_ch.func;
      key_r   <= in_ch.node_key[KEY_BITS-1:0];
      loc_r   <= in_ch.location_present ? in_ch.location_data[LOC_BITS-1:0] : '0;
      epoch_r <= in_ch.wall_secs;
      now_r   <= in_ch.now_ms;
      idx_r   <= in_ch.entry_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= STALE_LIMIT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // slot memory: one read port (registered), one write port
  assign rd_addr = cmd.rd_use_idx ? IDX_W'(idx_r) : cmd.rd_addr;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
    if (do_write) begin
      mem[wr_slot] <= '{key: key_r, loc: loc_r, epoch: epoch_r, last_seen: now_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en && !cmd.rd_use_idx;
    end
    if (cmd.rd_en) begin
      rd_idx_r <= rd_addr;
    end
  end

  assign rd_age = now_r - rd_q_r.last_seen;

  // first key match, and oldest slot with the lowest index winning ties
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      found_r    <= 1'b0;
      best_vld_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (!found_r && rd_q_r.key == key_r) begin
        found_r      <= 1'b1;
        found_slot_r <= rd_idx_r;
        found_age_r  <= rd_age;
      end
      if (!best_vld_r || rd_age > best_age_r) begin
        best_vld_r  <= 1'b1;
        best_slot_r <= rd_idx_r;
        best_age_r  <= rd_age;
      end
    end
  end

  assign full     = (occ_r == CNT_W'(ENTRIES));
  assign do_write = cmd.finish && func_r == FN_TOUCH && key_r != '0;

  always_comb begin
    wr_slot = best_slot_r;
    occ_nxt = occ_r;
    if (found_r) begin
      wr_slot = found_slot_r;
    end else if (!full) begin
      wr_slot = occ_r[IDX_W-1:0];
      if (do_write) begin
        occ_nxt = occ_r + 1'b1;
      end
    end
  end

  assign rd_in_range = ({{CNT_W{1'b0}}, idx_r} < {{IDXF_W{1'b0}}, occ_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (cmd.finish) begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      stale_r   <= 1'b0;
      ev_r      <= 1'b0;
      ekey_r    <= '0;
      eloc_r    <= '0;
      eepoch_r  <= '0;
      elast_r   <= '0;
      eonline_r <= 1'b0;
      tslot_r   <= '0;
      occ_out_r <= OCCF_W'(occ_nxt);
      unique case (func_r)
        FN_TOUCH: begin
          if (do_write) begin
            tslot_r <= IDXF_W'(wr_slot);
          end
        end
        FN_QUERY: begin
          stale_r <= (key_r == '0) || !found_r || (found_age_r >= limit_r);
        end
        FN_READ: begin
          if (rd_in_range) begin
            ev_r      <= 1'b1;
            ekey_r    <= KEYF_W'(rd_q_r.key);
            eloc_r    <= LOCF_W'(rd_q_r.loc);
            eepoch_r  <= rd_q_r.epoch;
            elast_r   <= rd_q_r.last_seen;
            eonline_r <= (now_r - rd_q_r.last_seen) < limit_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.stale           = stale_r;
  assign out_ch.entry_valid     = ev_r;
  assign out_ch.entry_key       = ekey_r;
  assign out_ch.entry_location  = eloc_r;
  assign out_ch.entry_epoch     = eepoch_r;
  assign out_ch.entry_last_seen = elast_r;
  assign out_ch.entry_online    = eonline_r;
  assign out_ch.occupied_count  = occ_out_r;
  assign out_ch.touched_slot    = tslot_r;

endmodule

`default_nettype wire

[hw/rtl/node_roster_table_core.sv]
// ----------------------------------------------------------------------------
// node_roster_table_core
// Roster of network nodes with key lookup and oldest-entry replacement.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        contents
//  in_if     in   valid/ready      func, key, location, epoch, now, index
//  out_if    out  valid/ready      stale, entry fields, occupied, slot
//  cfg_*     in   cfg_we           stale limit in ms
//
//  A touch or stale query with a non-zero key scans the roster with one slot
//  memory read per occupied slot; a read by index reads one slot; other items
//  go from decode straight to the final step. One item is in flight at a time;
//  the next is taken once the previous result sits in the output register. A
//  stalled output holds the block in its final step. Reset empties the roster.
// ----------------------------------------------------------------------------
`default_nettype none

module node_roster_table_core import nrt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  nrt_in_if.sink                 in_if,
  nrt_out_if.source              out_if,
  input  wire logic              cfg_we,
  input  wire logic [TIME_W-1:0] cfg_wdata
);

  nrt_cmd_t cmd;
  nrt_sts_t sts;

  nrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nrt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for node_roster_table_core. Drives touch, stale query
// and read operations over the request channel with random idle and
// back-pressure. Each result is checked against a local model or a fixed expectation.
// The run steps through several stale limit settings.
// ----------------------------------------------------------------------------
module testbench;
  import nrt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;
  localparam int KEY_POOL    = 24;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 340;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 24;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEYF_W-1:0] node_key;
    logic [LOCF_W-1:0] location_data;
    logic              location_present;
    logic [TIME_W-1:0] wall_secs;
    logic [TIME_W-1:0] now_ms;
    logic [IDXF_W-1:0] entry_index;
  } roster_req_t;

  typedef struct packed {
    logic              stale;
    logic              entry_valid;
    logic [KEYF_W-1:0] entry_key;
    logic [LOCF_W-1:0] entry_location;
    logic [TIME_W-1:0] entry_epoch;
    logic [TIME_W-1:0] entry_last_seen;
    logic              entry_online;
    logic [OCCF_W-1:0] occupied_count;
    logic [IDXF_W-1:0] touched_slot;
  } roster_rsp_t;

  typedef struct {
    roster_req_t req;
    bit          typed;
    roster_rsp_t rsp;
  } probe_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [TIME_W-1:0] cfg_wdata;

  nrt_in_if  in_ch ();
  nrt_out_if out_ch ();

  node_roster_table_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // roster mirror
  logic [KEY_BITS-1:0] key_tab    [ENTRIES];
  logic [LOC_BITS-1:0] loc_tab    [ENTRIES];
  logic [TIME_W-1:0]   epoch_tab  [ENTRIES];
  logic [TIME_W-1:0]   seen_tab   [ENTRIES];
  logic                online_tab [ENTRIES];
  int                  fill = 0;
  logic [TIME_W-1:0]   stale_limit = STALE_LIMIT_RST;

  roster_rsp_t       pending_q[$];
  probe_row_t        probes[$];
  logic [KEYF_W-1:0] key_pool [KEY_POOL];
  logic [TIME_W-1:0] clock_ms;
  int                mismatches = 0;
  bit                hold_req = 0;
  bit                src_quiet = 0;
  bit                snk_quiet = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [TIME_W-1:0] age_ms(int s, logic [TIME_W-1:0] now);
    return now - seen_tab[s];
  endfunction

  function automatic roster_rsp_t roster_apply(roster_req_t r);
    roster_rsp_t o;
    int          slot;
    o = '0;
    case (r.func)
      FN_TOUCH: begin
        if (r.node_key != '0) begin
          slot = -1;
          for (int i = 0; i < fill; i++)
            if (slot < 0 && key_tab[i] == r.node_key) slot = i;
          if (slot < 0) begin
            if (fill < ENTRIES) begin
              slot = fill;
              fill++;
            end else begin
              // evict the oldest, lowest slot wins a tie
              slot = 0;
              for (int i = 1; i < ENTRIES; i++)
                if (age_ms(i, r.now_ms) > age_ms(slot, r.now_ms)) slot = i;
            end
          end
          key_tab[slot]    = r.node_key;
          loc_tab[slot]    = r.location_present ? r.location_data : '0;
          epoch_tab[slot]  = r.wall_secs;
          seen_tab[slot]   = r.now_ms;
          online_tab[slot] = (stale_limit != 0);
          o.touched_slot   = slot[IDXF_W-1:0];
        end
      end
      FN_QUERY: begin
        slot = -1;
        if (r.node_key != '0)
          for (int i = 0; i < fill; i++)
            if (slot < 0 && key_tab[i] == r.node_key) slot = i;
        o.stale = (slot < 0) ? 1'b1 : (age_ms(slot, r.now_ms) >= stale_limit);
      end
      FN_READ: begin
        for (int i = 0; i < fill; i++)
          online_tab[i] = (age_ms(i, r.now_ms) < stale_limit);
        if (int'(r.entry_index) < fill) begin
          o.entry_valid     = 1'b1;
          o.entry_key       = key_tab[r.entry_index];
          o.entry_location  = loc_tab[r.entry_index];
          o.entry_epoch     = epoch_tab[r.entry_index];
          o.entry_last_seen = seen_tab[r.entry_index];
          o.entry_online    = online_tab[r.entry_index];
        end
      end
      default: ;
    endcase
    o.occupied_count = fill[OCCF_W-1:0];
    return o;
  endfunction

  function automatic roster_req_t random_item();
    roster_req_t r;
    int          pick;
    pick = $urandom_range(99);
    r.func = pick < 45 ? FN_TOUCH : pick < 75 ? FN_QUERY : pick < 95 ? FN_READ : FN_SPARE;
    pick = $urandom_range(99);
    if (pick < 5) r.node_key = '0;
    else if (pick < 15) r.node_key = {$urandom, $urandom};
    else if (pick < 45 && fill > 0) r.node_key = key_tab[$urandom_range(fill - 1)];
    else r.node_key = key_pool[$urandom_range(KEY_POOL - 1)];
    r.location_data    = {$urandom, $urandom};
    r.location_present = 1'($urandom_range(1));
    r.wall_secs        = $urandom;
    r.entry_index      = IDXF_W'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 10 && fill > 0) begin
      // land on or just short of the stale boundary of a live slot
      r.now_ms = seen_tab[$urandom_range(fill - 1)] + stale_limit - $urandom_range(1);
    end else if (pick < 20) begin
      r.now_ms = clock_ms - $urandom_range(3);
    end else if (pick < 25) begin
      clock_ms = $urandom;
      r.now_ms = clock_ms;
    end else begin
      case ($urandom_range(2))
        0:       clock_ms += $urandom_range(3);
        1:       clock_ms += $urandom_range(1000);
        default: clock_ms += $urandom_range(40000);
      endcase
      r.now_ms = clock_ms;
    end
    return r;
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function void cmp_field(string name, logic [63:0] exp, logic [63:0] act);
    if (act !== exp) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      mismatches++;
    end
  endfunction

  task automatic send(roster_req_t r, bit typed, roster_rsp_t e);
    int gap;
    roster_rsp_t pred;
    gap = pick_gap(src_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.func             <= r.func;
    in_ch.node_key         <= r.node_key;
    in_ch.location_data    <= r.location_data;
    in_ch.location_present <= r.location_present;
    in_ch.wall_secs        <= r.wall_secs;
    in_ch.now_ms           <= r.now_ms;
    in_ch.entry_index      <= r.entry_index;
    do @(posedge clk); while (!in_ch.ready);
    pred = roster_apply(r);
    pending_q.push_back(typed ? e : pred);
  endtask

  task automatic drain_and_write(logic [TIME_W-1:0] v);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    stale_limit = v;
  endtask

  task automatic probe(roster_req_t r, bit typed, roster_rsp_t e);
    probe_row_t p;
    p.req   = r;
    p.typed = typed;
    p.rsp   = e;
    probes.push_back(p);
  endtask

  // directed rows: typed expectations only where obvious
  task automatic build_probes();
    roster_rsp_t none;
    none = '0;
    probe('{FN_READ, 64'h0, 64'h0, 1'b0, 32'h0, 32'h0, 4'd0}, 1'b1, none);
    probe('{FN_QUERY, 64'h0, 64'h0, 1'b0, 32'h0, 32'h0, 4'd0}, 1'b1,
          '{1'b1, 1'b0, 64'h0, 64'h0, 32'h0, 32'h0, 1'b0, 5'd0, 4'd0});
    probe('{FN_TOUCH, 64'h0, '1, 1'b1, '1, 32'h10, 4'd0}, 1'b1, none);
    probe('{FN_SPARE, '1, '1, 1'b1, '1, '1, 4'd15}, 1'b1, none);
    probe('{FN_QUERY, '1, 64'h0, 1'b0, 32'h0, 32'h0, 4'd0}, 1'b1,
          '{1'b1, 1'b0, 64'h0, 64'h0, 32'h0, 32'h0, 1'b0, 5'd0, 4'd0});
    probe('{FN_TOUCH, '1, '1, 1'b1, '1, 32'h0, 4'd0}, 1'b1,
          '{1'b0, 1'b0, 64'h0, 64'h0, 32'h0, 32'h0, 1'b0, 5'd1, 4'd0});
    // location not present: payload must be dropped
    probe('{FN_TOUCH, 64'h1, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 32'h0, 32'd100, 4'd0}, 1'b1,
          '{1'b0, 1'b0, 64'h0, 64'h0, 32'h0, 32'h0, 1'b0, 5'd2, 4'd1});
    probe('{FN_READ, 64'h0, 64'h0, 1'b0, 32'h0, 32'd100, 4'd0}, 1'b1,
          '{1'b0, 1'b1, '1, '1, '1, 32'h0, 1'b1, 5'd2, 4'd0});
    probe('{FN_READ, 64'h0, 64'h0, 1'b0, 32'h0, 32'd100, 4'd1}, 1'b1,
          '{1'b0, 1'b1, 64'h1, 64'h0, 32'h0, 32'd100, 1'b1, 5'd2, 4'd0});
    probe('{FN_READ, 64'h0, 64'h0, 1'b0, 32'h0, 32'd100, 4'd15}, 1'b1,
          '{1'b0, 1'b0, 64'h0, 64'h0, 32'h0, 32'h0, 1'b0, 5'd2, 4'd0});
    probe('{FN_QUERY, '1, 64'h0, 1'b0, 32'h0, 32'd60000, 4'd0}, 1'b1,
          '{1'b1, 1'b0, 64'h0, 64'h0, 32'h0, 32'h0, 1'b0, 5'd2, 4'd0});
    probe('{FN_QUERY, '1, 64'h0, 1'b0, 32'h0, 32'd59999, 4'd0}, 1'b1,
          '{1'b0, 1'b0, 64'h0, 64'h0, 32'h0, 32'h0, 1'b0, 5'd2, 4'd0});
    // now behind last seen: age wraps to the maximum
    probe('{FN_QUERY, 64'h1, 64'h0, 1'b0, 32'h0, 32'd99, 4'd0}, 1'b1,
          '{1'b1, 1'b0, 64'h0, 64'h0, 32'h0, 32'h0, 1'b0, 5'd2, 4'd0});
    probe('{FN_TOUCH, '1, 64'h0123_4567_89AB_CDEF, 1'b1, 32'd1234, 32'd5, 4'd0}, 1'b1,
          '{1'b0, 1'b0, 64'h0, 64'h0, 32'h0, 32'h0, 1'b0, 5'd2, 4'd0});
    probe('{FN_TOUCH, 64'h8000_0000_0000_0000, '1, 1'b1, 32'd7, '1, 4'd0}, 1'b0, none);
    probe('{FN_READ, 64'h0, 64'h0, 1'b0, 32'h0, '1, 4'd2}, 1'b0, none);
    probe('{FN_READ, 64'h0, 64'h0, 1'b0, 32'h0, 32'd60100, 4'd1}, 1'b1,
          '{1'b0, 1'b1, 64'h1, 64'h0, 32'h0, 32'd100, 1'b0, 5'd3, 4'd0});
    probe('{FN_QUERY, 64'h2, 64'h0, 1'b0, 32'h0, 32'd100, 4'd0}, 1'b1,
          '{1'b1, 1'b0, 64'h0, 64'h0, 32'h0, 32'h0, 1'b0, 5'd3, 4'd0});
    probe('{FN_SPARE, 64'h1, '1, 1'b1, '1, 32'd100, 4'd1}, 1'b0, none);
    probe('{FN_TOUCH, 64'h1, '1, 1'b1, 32'd9, 32'd200, 4'd0}, 1'b0, none);
  endtask

  // request side
  initial begin
    logic [TIME_W-1:0] limits [PHASES];
    roster_rsp_t none;
    none = '0;
    rst_n                  <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_wdata              <= '0;
    in_ch.valid            <= 1'b0;
    in_ch.func             <= FN_TOUCH;
    in_ch.node_key         <= '0;
    in_ch.location_data    <= '0;
    in_ch.location_present <= 1'b0;
    in_ch.wall_secs        <= '0;
    in_ch.now_ms           <= '0;
    in_ch.entry_index      <= '0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom} | 64'h1;
    clock_ms = $urandom;
    limits[0] = STALE_LIMIT_RST;
    limits[1] = 32'd1;
    limits[2] = '1;
    limits[3] = '0;
    limits[4] = $urandom;
    build_probes();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probes[i]) send(probes[i].req, probes[i].typed, probes[i].rsp);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) drain_and_write(limits[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 2) src_quiet = !src_quiet;
        if (n == 100 && ph % 2 == 1) begin
          // sink holds off while we keep offering, so the block backs up
          src_quiet = 1'b1;
          hold_req  = 1'b1;
        end
        send(random_item(), 1'b0, none);
      end
      in_ch.valid <= 1'b0;
    end

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  // result side
  initial begin
    int stall_left;
    roster_rsp_t e;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_q.size() == 0) begin
          $error("result item with no expectation pending");
          mismatches++;
        end else begin
          e = pending_q.pop_front();
          cmp_field("stale", e.stale, out_ch.stale);
          cmp_field("entry_valid", e.entry_valid, out_ch.entry_valid);
          cmp_field("entry_key", e.entry_key, out_ch.entry_key);
          cmp_field("entry_location", e.entry_location, out_ch.entry_location);
          cmp_field("entry_epoch", e.entry_epoch, out_ch.entry_epoch);
          cmp_field("entry_last_seen", e.entry_last_seen, out_ch.entry_last_seen);
          cmp_field("entry_online", e.entry_online, out_ch.entry_online);
          cmp_field("occupied_count", e.occupied_count, out_ch.occupied_count);
          cmp_field("touched_slot", e.touched_slot, out_ch.touched_slot);
        end
      end
      if ($urandom_range(99) == 0) snk_quiet = !snk_quiet;
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap(snk_quiet);
      end
    end
  end

  // watchdog: cycles with no item moving on either channel
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle = 0;
      else
        idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
hw/rtl/nrt_pkg.sv
hw/rtl/nrt_in_if.sv
hw/rtl/nrt_out_if.sv
hw/rtl/nrt_ctrl.sv
hw/rtl/nrt_dp.sv
hw/rtl/node_roster_table_core.sv
tb/testbench.sv
